// ===== hdl/pdi_pkg.sv =====
// shared constants, types, microcode table and helpers for the drag integrator
`timescale 1ns / 1ps
package pdi_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int K_FRAC    = 24;

    // field and state widths
    localparam int CMD_W    = 1;
    localparam int LVX_W    = 25;
    localparam int LVY_W    = 25;
    localparam int LH_W     = 26;
    localparam int DRAG_K_W = 32;
    localparam int GRAV_W   = 23;
    localparam int DT_W     = 20;
    localparam int TGT_W    = 33;
    localparam int MARGIN_W = 23;
    localparam int STATE_W  = 40;
    localparam int TIME_W   = 40;
    localparam int PEAK_W   = 39;
    localparam int DT2_W    = 2 * DT_W;

    // multiplier widths
    localparam int A_W     = STATE_W;
    localparam int MAG_W   = STATE_W + 1;
    localparam int CHUNK_W = (MAG_W + 1) / 2;
    localparam int PP_W    = A_W + CHUNK_W;
    localparam int PROD_W  = A_W + 2 * CHUNK_W;
    localparam int RES_W   = MAG_W + 1;
    localparam int ACC_W   = STATE_W + 4;

    // configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int REG_LSB    = 3;
    localparam int REG_IDX_W  = CFG_ADDR_W - REG_LSB;

    localparam logic [REG_IDX_W-1:0] REG_DRAG_K        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_X      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_Y      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_MARGIN = 3'd5;

    localparam logic [DRAG_K_W-1:0] DRAG_K_RST        = 32'd0;
    localparam logic [GRAV_W-1:0]   GRAVITY_RST       = 23'd642908;
    localparam logic [DT_W-1:0]     TIME_STEP_RST     = 20'd6554;
    localparam logic [TGT_W-1:0]    TARGET_X_RST      = 33'd851968;
    localparam logic [TGT_W-1:0]    TARGET_Y_RST      = 33'd393216;
    localparam logic [MARGIN_W-1:0] TARGET_MARGIN_RST = 23'd65536;

    // commands
    localparam logic [CMD_W-1:0] CMD_LAUNCH  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 1'b1;

    // microcode fields
    localparam int OP_W   = 3;
    localparam int COND_W = 2;
    localparam int ASEL_W = 3;
    localparam int BSEL_W = 2;
    localparam int SH_W   = 2;
    localparam int WB_W   = 4;
    localparam int UPC_W  = 4;

    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd1;
    localparam logic [OP_W-1:0] OP_LAUNCH = 3'd2;
    localparam logic [OP_W-1:0] OP_FIN    = 3'd3;
    localparam logic [OP_W-1:0] OP_OUT    = 3'd4;

    localparam logic [COND_W-1:0] COND_NONE   = 2'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS = 2'd1;
    localparam logic [COND_W-1:0] COND_LAUNCH = 2'd2;
    localparam logic [COND_W-1:0] COND_LANDED = 2'd3;

    localparam logic [ASEL_W-1:0] A_VY = 3'd0;
    localparam logic [ASEL_W-1:0] A_VX = 3'd1;
    localparam logic [ASEL_W-1:0] A_AY = 3'd2;
    localparam logic [ASEL_W-1:0] A_AX = 3'd3;
    localparam logic [ASEL_W-1:0] A_K  = 3'd4;
    localparam logic [ASEL_W-1:0] A_DT = 3'd5;

    localparam logic [BSEL_W-1:0] B_AMAG = 2'd0;
    localparam logic [BSEL_W-1:0] B_SQ   = 2'd1;
    localparam logic [BSEL_W-1:0] B_DT   = 2'd2;
    localparam logic [BSEL_W-1:0] B_DT2  = 2'd3;

    localparam logic [SH_W-1:0] SH_NONE = 2'd0;
    localparam logic [SH_W-1:0] SH_FRAC = 2'd1;
    localparam logic [SH_W-1:0] SH_K    = 2'd2;
    localparam logic [SH_W-1:0] SH_DT2  = 2'd3;

    localparam logic [WB_W-1:0] WB_NONE = 4'd0;
    localparam logic [WB_W-1:0] WB_SQ   = 4'd1;
    localparam logic [WB_W-1:0] WB_AY   = 4'd2;
    localparam logic [WB_W-1:0] WB_AX   = 4'd3;
    localparam logic [WB_W-1:0] WB_DT2  = 4'd4;
    localparam logic [WB_W-1:0] WB_SUMY = 4'd5;
    localparam logic [WB_W-1:0] WB_Y    = 4'd6;
    localparam logic [WB_W-1:0] WB_VY   = 4'd7;
    localparam logic [WB_W-1:0] WB_SUMX = 4'd8;
    localparam logic [WB_W-1:0] WB_X    = 4'd9;
    localparam logic [WB_W-1:0] WB_VX   = 4'd10;

    localparam logic [UPC_W-1:0] LBL_START  = 4'd0;
    localparam logic [UPC_W-1:0] LBL_OUT    = 4'd14;
    localparam logic [UPC_W-1:0] LBL_LAUNCH = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [ASEL_W-1:0] a_sel;
        logic [BSEL_W-1:0] b_sel;
        logic [SH_W-1:0]   sh_sel;
        logic [WB_W-1:0]   wb;
        logic [UPC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic              go;
        logic              fire;
        logic [OP_W-1:0]   op;
        logic [ASEL_W-1:0] a_sel;
        logic [BSEL_W-1:0] b_sel;
        logic [SH_W-1:0]   sh_sel;
        logic [WB_W-1:0]   wb;
    } ctrl_t;

    typedef struct packed {
        logic [DRAG_K_W-1:0] drag_k;
        logic [GRAV_W-1:0]   gravity;
        logic [DT_W-1:0]     time_step;
        logic [TGT_W-1:0]    target_x;
        logic [TGT_W-1:0]    target_y;
        logic [MARGIN_W-1:0] target_margin;
    } cfg_t;

    typedef struct packed {
        logic signed [STATE_W-1:0] pos_x;
        logic signed [STATE_W-1:0] pos_y;
        logic signed [STATE_W-1:0] vel_x;
        logic signed [STATE_W-1:0] vel_y;
        logic [TIME_W-1:0]         elapsed;
        logic [PEAK_W-1:0]         peak_height;
        logic [TIME_W-1:0]         hit_time;
        logic                      hit_valid;
        logic                      landed;
    } result_t;

    // saturation bounds of the signed state range
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

    // clamp a wide sum into the signed state range
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[STATE_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[STATE_W-1:0];
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

    // sign-extend a state value to the accumulator width
    function automatic logic signed [ACC_W-1:0] sext_state(
        input logic signed [STATE_W-1:0] v);
        return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    // microprogram: dispatch, eleven multiplies, finish, output, launch
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            4'd0:  w = '{OP_NOP, COND_LAUNCH, A_VY, B_DT, SH_NONE, WB_NONE, LBL_LAUNCH};
            4'd1:  w = '{OP_NOP, COND_LANDED, A_VY, B_DT, SH_NONE, WB_NONE, LBL_OUT};
            4'd2:  w = '{OP_MUL, COND_NONE, A_VY, B_AMAG, SH_FRAC, WB_SQ, LBL_START};
            4'd3:  w = '{OP_MUL, COND_NONE, A_K, B_SQ, SH_K, WB_AY, LBL_START};
            4'd4:  w = '{OP_MUL, COND_NONE, A_VX, B_AMAG, SH_FRAC, WB_SQ, LBL_START};
            4'd5:  w = '{OP_MUL, COND_NONE, A_K, B_SQ, SH_K, WB_AX, LBL_START};
            4'd6:  w = '{OP_MUL, COND_NONE, A_DT, B_DT, SH_NONE, WB_DT2, LBL_START};
            4'd7:  w = '{OP_MUL, COND_NONE, A_VY, B_DT, SH_FRAC, WB_SUMY, LBL_START};
            4'd8:  w = '{OP_MUL, COND_NONE, A_AY, B_DT2, SH_DT2, WB_Y, LBL_START};
            4'd9:  w = '{OP_MUL, COND_NONE, A_AY, B_DT, SH_FRAC, WB_VY, LBL_START};
            4'd10: w = '{OP_MUL, COND_NONE, A_VX, B_DT, SH_FRAC, WB_SUMX, LBL_START};
            4'd11: w = '{OP_MUL, COND_NONE, A_AX, B_DT2, SH_DT2, WB_X, LBL_START};
            4'd12: w = '{OP_MUL, COND_NONE, A_AX, B_DT, SH_FRAC, WB_VX, LBL_START};
            4'd13: w = '{OP_FIN, COND_NONE, A_VY, B_DT, SH_NONE, WB_NONE, LBL_START};
            4'd14: w = '{OP_OUT, COND_NONE, A_VY, B_DT, SH_NONE, WB_NONE, LBL_START};
            4'd15: w = '{OP_LAUNCH, COND_ALWAYS, A_VY, B_DT, SH_NONE, WB_NONE, LBL_OUT};
            default: w = '{OP_OUT, COND_NONE, A_VY, B_DT, SH_NONE, WB_NONE, LBL_START};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/pdi_if.sv =====
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps
interface pdi_req_if import pdi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [LVX_W-1:0] launch_vx;
    logic [LVY_W-1:0] launch_vy;
    logic [LH_W-1:0]  launch_height;

    modport source (
        output valid, cmd, launch_vx, launch_vy, launch_height,
        input  ready
    );
    modport sink (
        input  valid, cmd, launch_vx, launch_vy, launch_height,
        output ready
    );
endinterface

interface pdi_rsp_if import pdi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [STATE_W-1:0] pos_x;
    logic signed [STATE_W-1:0] pos_y;
    logic signed [STATE_W-1:0] vel_x;
    logic signed [STATE_W-1:0] vel_y;
    logic [TIME_W-1:0]         elapsed;
    logic [PEAK_W-1:0]         peak_height;
    logic [TIME_W-1:0]         hit_time;
    logic                      hit_valid;
    logic                      landed;

    modport source (
        output valid, pos_x, pos_y, vel_x, vel_y, elapsed, peak_height,
               hit_time, hit_valid, landed,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, vel_x, vel_y, elapsed, peak_height,
               hit_time, hit_valid, landed,
        output ready
    );
endinterface

// ===== hdl/pdi_cfg_regs.sv =====
// apb configuration register bank
`timescale 1ns / 1ps
module pdi_cfg_regs import pdi_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg, cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_W-1:REG_LSB];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_DRAG_K:        cfg_next.drag_k        = pwdata[DRAG_K_W-1:0];
                REG_GRAVITY:       cfg_next.gravity       = pwdata[GRAV_W-1:0];
                REG_TIME_STEP:     cfg_next.time_step     = pwdata[DT_W-1:0];
                REG_TARGET_X:      cfg_next.target_x      = pwdata[TGT_W-1:0];
                REG_TARGET_Y:      cfg_next.target_y      = pwdata[TGT_W-1:0];
                REG_TARGET_MARGIN: cfg_next.target_margin = pwdata[MARGIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // readback mux
    always_comb
    begin
        case (idx)
            REG_DRAG_K:        prdata = CFG_DATA_W'(cfg_reg.drag_k);
            REG_GRAVITY:       prdata = CFG_DATA_W'(cfg_reg.gravity);
            REG_TIME_STEP:     prdata = CFG_DATA_W'(cfg_reg.time_step);
            REG_TARGET_X:      prdata = CFG_DATA_W'(cfg_reg.target_x);
            REG_TARGET_Y:      prdata = CFG_DATA_W'(cfg_reg.target_y);
            REG_TARGET_MARGIN: prdata = CFG_DATA_W'(cfg_reg.target_margin);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{drag_k:        DRAG_K_RST,
                         gravity:       GRAVITY_RST,
                         time_step:     TIME_STEP_RST,
                         target_x:      TARGET_X_RST,
                         target_y:      TARGET_Y_RST,
                         target_margin: TARGET_MARGIN_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/pdi_mul_unit.sv =====
// shared multi-cycle multiplier with shift, magnitude clamp and sign restore
`timescale 1ns / 1ps
module pdi_mul_unit import pdi_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [A_W-1:0]           a_mag,
    input  logic                     a_neg,
    input  logic [MAG_W-1:0]         b,
    input  logic [SH_W-1:0]          sh_sel,
    output logic                     done,
    output logic signed [RES_W-1:0]  res
);

    localparam logic [2:0] PH_LO   = 3'd0;
    localparam logic [2:0] PH_HI   = 3'd1;
    localparam logic [2:0] PH_SUM  = 3'd2;
    localparam logic [2:0] PH_SAT  = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    localparam logic [PROD_W-1:0] MAG_LIM =
        {{(PROD_W-MAG_W){1'b0}}, 1'b1, {(MAG_W-1){1'b0}}};

    logic [2:0]                phase_reg, phase_next;
    logic [2*CHUNK_W-1:0]      b_ext;
    logic [CHUNK_W-1:0]        chunk;
    logic [PP_W-1:0]           pp_reg, pp_next;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         shifted;
    logic [MAG_W-1:0]          mag_sat;
    logic signed [RES_W-1:0]   res_reg, res_next;

    assign done = go && (phase_reg == PH_DONE);
    assign res  = res_reg;

    // one 40x21 partial product per cycle, low chunk first
    assign b_ext   = {{(2*CHUNK_W-MAG_W){1'b0}}, b};
    assign chunk   = (phase_reg == PH_LO) ? b_ext[CHUNK_W-1:0]
                                          : b_ext[2*CHUNK_W-1:CHUNK_W];
    assign pp_next = PP_W'(a_mag) * PP_W'(chunk);

    // fixed-point shift chosen by the control word
    always_comb
    begin
        case (sh_sel)
            SH_NONE: shifted = prod_reg;
            SH_FRAC: shifted = prod_reg >> FRAC_BITS;
            SH_K:    shifted = prod_reg >> K_FRAC;
            SH_DT2:  shifted = prod_reg >> (2 * FRAC_BITS + 1);
            default: shifted = prod_reg;
        endcase
    end

    // clamp magnitude at 2^40 and restore sign of the first operand
    assign mag_sat  = (shifted > MAG_LIM) ? MAG_LIM[MAG_W-1:0] : shifted[MAG_W-1:0];
    assign res_next = a_neg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

    // phase counter
    always_comb
    begin
        if (!go || phase_reg == PH_DONE)
            phase_next = PH_LO;
        else
            phase_next = phase_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_LO;
        else
            phase_reg <= phase_next;
    end

    // product datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            PH_LO:
            begin
                pp_reg <= pp_next;
            end
            PH_HI:
            begin
                prod_reg <= PROD_W'(pp_reg);
                pp_reg   <= pp_next;
            end
            PH_SUM:
            begin
                prod_reg <= prod_reg + (PROD_W'(pp_reg) << CHUNK_W);
            end
            PH_SAT:
            begin
                res_reg <= res_next;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

// ===== hdl/pdi_sequencer.sv =====
// microprogram counter, control store and branch logic
`timescale 1ns / 1ps
module pdi_sequencer import pdi_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  is_launch,
    input  logic  landed,
    input  logic  mul_done,
    input  logic  out_free,
    output logic  busy,
    output ctrl_t ctrl
);

    logic             busy_reg, busy_next;
    logic [UPC_W-1:0] upc_reg, upc_next;
    uword_t           word;
    logic             cond_hit;
    logic             advance;

    assign word = ucode(upc_reg);
    assign busy = busy_reg;

    // branch condition
    always_comb
    begin
        case (word.cond)
            COND_NONE:   cond_hit = 1'b0;
            COND_ALWAYS: cond_hit = 1'b1;
            COND_LAUNCH: cond_hit = is_launch;
            COND_LANDED: cond_hit = landed;
            default:     cond_hit = 1'b0;
        endcase
    end

    // a busy word retires when the multiplier is done for a multiply and the output slot is free for an output
    assign advance = busy_reg
                  && (word.op != OP_MUL || mul_done)
                  && (word.op != OP_OUT || out_free);

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = LBL_START;
        end
        else if (advance)
        begin
            if (word.op == OP_OUT)
            begin
                busy_next = 1'b0;
                upc_next  = LBL_START;
            end
            else if (cond_hit)
            begin
                upc_next = word.target;
            end
            else
            begin
                upc_next = upc_reg + UPC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= LBL_START;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    // control word to the datapath and multiplier
    always_comb
    begin
        ctrl.go     = busy_reg && (word.op == OP_MUL);
        ctrl.fire   = advance;
        ctrl.op     = word.op;
        ctrl.a_sel  = word.a_sel;
        ctrl.b_sel  = word.b_sel;
        ctrl.sh_sel = word.sh_sel;
        ctrl.wb     = word.wb;
    end

endmodule

// ===== hdl/pdi_datapath.sv =====
// flight state registers, operand selection and writeback
`timescale 1ns / 1ps
module pdi_datapath import pdi_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  cfg_t                    cfg,
    input  logic                    take,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [LVX_W-1:0]        launch_vx,
    input  logic [LVY_W-1:0]        launch_vy,
    input  logic [LH_W-1:0]         launch_height,
    input  logic signed [RES_W-1:0] res,
    output logic [A_W-1:0]          a_mag,
    output logic                    a_neg,
    output logic [MAG_W-1:0]        b,
    output logic                    is_launch,
    output logic                    landed,
    output result_t                 state
);

    // latched transaction
    logic [CMD_W-1:0] cmd_reg;
    logic [LVX_W-1:0] lvx_reg;
    logic [LVY_W-1:0] lvy_reg;
    logic [LH_W-1:0]  lh_reg;

    // architectural state
    logic signed [STATE_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [STATE_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [TIME_W-1:0]         time_reg, time_next, stamp_reg, stamp_next;
    logic [PEAK_W-1:0]         peak_reg, peak_next;
    logic                      seen_reg, seen_next, landed_reg, landed_next;

    // scratch registers
    logic [MAG_W-1:0]          sq_reg, sq_next;
    logic signed [STATE_W-1:0] ay_reg, ay_next, ax_reg, ax_next;
    logic [DT2_W-1:0]          dt2_reg, dt2_next;
    logic signed [ACC_W-1:0]   sum_reg, sum_next;

    logic [STATE_W-1:0]        a_val;
    logic signed [ACC_W-1:0]   res_e, grav_e, drag_y, drag_x;
    logic signed [ACC_W-1:0]   tx_e, ty_e, mg_e, x_e, y_e;
    logic signed [STATE_W-1:0] fin_sat;
    logic [MAG_W-1:0]          res_mag;
    logic [TIME_W:0]           time_sum;
    logic                      hit;

    assign is_launch = (cmd_reg == CMD_LAUNCH);
    assign landed    = landed_reg;

    // first multiplier operand and its sign
    always_comb
    begin
        case (ctrl.a_sel)
            A_VY:    a_val = vy_reg;
            A_VX:    a_val = vx_reg;
            A_AY:    a_val = ay_reg;
            A_AX:    a_val = ax_reg;
            A_K:     a_val = STATE_W'(cfg.drag_k);
            A_DT:    a_val = STATE_W'(cfg.time_step);
            default: a_val = '0;
        endcase
    end

    assign a_neg = a_val[STATE_W-1];
    assign a_mag = a_neg ? (~a_val + A_W'(1)) : a_val;

    // second multiplier operand
    always_comb
    begin
        case (ctrl.b_sel)
            B_AMAG:  b = MAG_W'(a_mag);
            B_SQ:    b = sq_reg;
            B_DT:    b = MAG_W'(cfg.time_step);
            B_DT2:   b = MAG_W'(dt2_reg);
            default: b = '0;
        endcase
    end

    // writeback arithmetic
    assign res_e   = {{(ACC_W-RES_W){res[RES_W-1]}}, res};
    assign grav_e  = $signed({{(ACC_W-GRAV_W){1'b0}}, cfg.gravity});
    assign drag_y  = vy_reg[STATE_W-1] ? res_e : -res_e;
    assign drag_x  = vx_reg[STATE_W-1] ? res_e : -res_e;
    assign fin_sat = sat_state(sum_reg + res_e);

    // the square of a speed is a magnitude whatever the speed's sign
    assign res_mag = res[RES_W-1] ? MAG_W'(-res) : res[MAG_W-1:0];

    // target window test on the new point
    assign tx_e = $signed({{(ACC_W-TGT_W){1'b0}}, cfg.target_x});
    assign ty_e = $signed({{(ACC_W-TGT_W){1'b0}}, cfg.target_y});
    assign mg_e = $signed({{(ACC_W-MARGIN_W){1'b0}}, cfg.target_margin});
    assign x_e  = sext_state(x_reg);
    assign y_e  = sext_state(y_reg);
    assign hit  = (x_e < tx_e + mg_e) && (x_e > tx_e - mg_e)
               && (y_e < ty_e + mg_e) && (y_e > ty_e - mg_e);

    // saturating time advance
    assign time_sum = {1'b0, time_reg} + (TIME_W+1)'(cfg.time_step);

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        time_next   = time_reg;
        stamp_next  = stamp_reg;
        peak_next   = peak_reg;
        seen_next   = seen_reg;
        landed_next = landed_reg;
        sq_next     = sq_reg;
        ay_next     = ay_reg;
        ax_next     = ax_reg;
        dt2_next    = dt2_reg;
        sum_next    = sum_reg;
        if (ctrl.fire)
        begin
            case (ctrl.op)
                OP_LAUNCH:
                begin
                    x_next      = '0;
                    y_next      = STATE_W'(lh_reg);
                    vx_next     = STATE_W'(lvx_reg);
                    vy_next     = STATE_W'(lvy_reg);
                    time_next   = '0;
                    stamp_next  = '0;
                    peak_next   = '0;
                    seen_next   = 1'b0;
                    landed_next = 1'b0;
                end
                OP_FIN:
                begin
                    if (hit)
                    begin
                        stamp_next = time_reg;
                        seen_next  = 1'b1;
                    end
                    time_next   = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
                    landed_next = y_reg[STATE_W-1];
                end
                OP_MUL:
                begin
                    case (ctrl.wb)
                        WB_SQ:   sq_next  = res_mag;
                        WB_AY:   ay_next  = sat_state(drag_y - grav_e);
                        WB_AX:   ax_next  = sat_state(drag_x);
                        WB_DT2:  dt2_next = res[DT2_W-1:0];
                        WB_SUMY: sum_next = y_e + res_e;
                        WB_Y:
                        begin
                            y_next = fin_sat;
                            if (fin_sat > $signed({1'b0, peak_reg}))
                                peak_next = fin_sat[PEAK_W-1:0];
                        end
                        WB_VY:   vy_next  = sat_state(sext_state(vy_reg) + res_e);
                        WB_SUMX: sum_next = x_e + res_e;
                        WB_X:    x_next   = fin_sat;
                        WB_VX:   vx_next  = sat_state(sext_state(vx_reg) + res_e);
                        default: sum_next = sum_reg;
                    endcase
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            time_reg   <= '0;
            stamp_reg  <= '0;
            peak_reg   <= '0;
            seen_reg   <= 1'b0;
            landed_reg <= 1'b1;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            time_reg   <= time_next;
            stamp_reg  <= stamp_next;
            peak_reg   <= peak_next;
            seen_reg   <= seen_next;
            landed_reg <= landed_next;
        end
    end

    // scratch values and the accepted transaction
    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        ay_reg  <= ay_next;
        ax_reg  <= ax_next;
        dt2_reg <= dt2_next;
        sum_reg <= sum_next;
        if (take)
        begin
            cmd_reg <= cmd;
            lvx_reg <= launch_vx;
            lvy_reg <= launch_vy;
            lh_reg  <= launch_height;
        end
    end

    // current state as a result transaction
    always_comb
    begin
        state.pos_x       = x_reg;
        state.pos_y       = y_reg;
        state.vel_x       = vx_reg;
        state.vel_y       = vy_reg;
        state.elapsed     = time_reg;
        state.peak_height = peak_reg;
        state.hit_time    = seen_reg ? stamp_reg : '0;
        state.hit_valid   = seen_reg;
        state.landed      = landed_reg;
    end

endmodule

// ===== hdl/projectile_drag_integrator_top.sv =====
// top level of the projectile drag integrator
`timescale 1ns / 1ps
// Integrates a 2-D projectile with quadratic drag in signed Q16 fixed point, one
// time step per advance command; a launch command loads the start velocity and
// height. Every command returns one result transaction with the state after it.
// A microprogram drives one shared multiplier that forms a 40x21 partial product
// per cycle and passes low, high, sum, saturate and done phases per product; an
// advance in flight runs eleven products plus dispatch, finish and output steps,
// and the block is busy, taking no new command, until its output step retires.
// Launches and advances after landing (or before any launch) run no products.
// A finished result waits in an output register while the next command is taken;
// the block only stalls at its output step if that register is still full.
// Configuration is written through the APB port at byte address 8*index, 64-bit.
module projectile_drag_integrator_top import pdi_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    pdi_req_if.sink               req,
    pdi_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                    cfg;
    ctrl_t                   ctrl;
    result_t                 state;
    result_t                 out_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    busy;
    logic                    take;
    logic                    out_free;
    logic                    out_load;
    logic                    is_launch;
    logic                    landed;
    logic                    mul_done;
    logic [A_W-1:0]          a_mag;
    logic                    a_neg;
    logic [MAG_W-1:0]        b;
    logic signed [RES_W-1:0] res;

    // input handshake
    assign req.ready = !busy;
    assign take      = req.valid && req.ready;

    // output slot
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = ctrl.fire && (ctrl.op == OP_OUT);

    pdi_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdi_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (take),
        .is_launch (is_launch),
        .landed    (landed),
        .mul_done  (mul_done),
        .out_free  (out_free),
        .busy      (busy),
        .ctrl      (ctrl)
    );

    pdi_mul_unit u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (ctrl.go),
        .a_mag  (a_mag),
        .a_neg  (a_neg),
        .b      (b),
        .sh_sel (ctrl.sh_sel),
        .done   (mul_done),
        .res    (res)
    );

    pdi_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cfg           (cfg),
        .take          (take),
        .cmd           (req.cmd),
        .launch_vx     (req.launch_vx),
        .launch_vy     (req.launch_vy),
        .launch_height (req.launch_height),
        .res           (res),
        .a_mag         (a_mag),
        .a_neg         (a_neg),
        .b             (b),
        .is_launch     (is_launch),
        .landed        (landed),
        .state         (state)
    );

    // output register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= state;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pos_x       = out_data_reg.pos_x;
    assign rsp.pos_y       = out_data_reg.pos_y;
    assign rsp.vel_x       = out_data_reg.vel_x;
    assign rsp.vel_y       = out_data_reg.vel_y;
    assign rsp.elapsed     = out_data_reg.elapsed;
    assign rsp.peak_height = out_data_reg.peak_height;
    assign rsp.hit_time    = out_data_reg.hit_time;
    assign rsp.hit_valid   = out_data_reg.hit_valid;
    assign rsp.landed      = out_data_reg.landed;

    // an accepted command always starts the microprogram
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy)
        else $error("accepted command did not start the sequencer");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("result register loaded while still full");

    // the multiplier only finishes inside a multiply word
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (ctrl.op == OP_MUL))
        else $error("multiplier done outside a multiply step");

endmodule

// ===== bench/tb_projectile_drag_integrator_top.sv =====
// testbench for the projectile drag integrator: directed table, random flights, predictor
`timescale 1ns / 1ps
module tb_projectile_drag_integrator_top;
    import pdi_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 5;
    localparam int     RANDOM_ITEMS = 400;
    localparam int     LONG_HOLD    = 400;
    localparam int     HOLD_PHASE   = 2;
    localparam int     END_CYCLES   = 70;
    localparam int     RUN_LIMIT    = 200000;
    localparam longint STATE_HI     = 64'sh7F_FFFF_FFFF;
    localparam longint STATE_LO     = -64'sh80_0000_0000;
    localparam logic [63:0] MAG_CAP  = 64'h100_0000_0000;
    localparam logic [63:0] TIME_CAP = 64'hFF_FFFF_FFFF;

    // state reported before any launch
    localparam result_t IDLE_STATE = '{0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1};

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [LVX_W-1:0] vx;
        logic [LVY_W-1:0] vy;
        logic [LH_W-1:0]  height;
        bit               fixed;
        result_t          fixed_state;
    } opening_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pdi_req_if req_ch ();
    pdi_rsp_if rsp_ch ();

    projectile_drag_integrator_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // flight state and register copy of the predictor
    cfg_t        model_cfg;
    longint      fl_x, fl_y, fl_vx, fl_vy, fl_peak;
    logic [63:0] fl_clock, fl_hit_at;
    bit          fl_hit, fl_down;

    result_t     expected_states[$];
    int          failures     = 0;
    int          live_items   = 0;
    int unsigned cycle_count  = 0;
    bit          tx_eager     = 1'b0;
    bit          rx_eager     = 1'b0;
    bit          rx_hold_req  = 1'b0;

    // directed opening sequence under the reset register values
    opening_row_t opening_rows [20] = '{
        // advance before any launch, then with every launch bit set
        '{CMD_ADVANCE, 0, 0, 0, 1'b1, IDLE_STATE},
        '{CMD_ADVANCE, '1, '1, '1, 1'b1, IDLE_STATE},
        // launch from the ground at rest still takes its first step
        '{CMD_LAUNCH, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0}},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        // top of the stated launch ranges
        '{CMD_LAUNCH, 19660800, 19660800, 65536000, 1'b1,
          '{0, 65536000, 19660800, 19660800, 0, 0, 0, 1'b0, 1'b0}},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        // full-width launch fields
        '{CMD_LAUNCH, '1, '1, '1, 1'b1,
          '{0, 67108863, 33554431, 33554431, 0, 0, 0, 1'b0, 1'b0}},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        // flat shot through the default target on the first step, hit at time zero
        '{CMD_LAUNCH, 8519680, 0, 393216, 1'b1,
          '{0, 393216, 8519680, 0, 0, 0, 0, 1'b0, 1'b0}},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        // ordinary lob from the ground
        '{CMD_LAUNCH, 655360, 1310720, 0, 1'b1,
          '{0, 0, 655360, 1310720, 0, 0, 0, 1'b0, 1'b0}},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0},
        '{CMD_ADVANCE, 0, 0, 0, 1'b0, '0}
    };

    // exact product, shifted, magnitude capped at 2^40
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int sh);
        logic [127:0] prod;
        logic [127:0] shifted;
        prod    = {64'd0, a} * {64'd0, b};
        shifted = prod >> sh;
        if (shifted > {64'd0, MAG_CAP})
            return MAG_CAP;
        return shifted[63:0];
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // sign-magnitude product, truncated toward zero
    function automatic longint scaled_signed(input longint a, input logic [63:0] b,
                                             input int sh);
        longint m;
        m = scaled_product(magnitude(a), b, sh);
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint clamp40(input longint v);
        if (v > STATE_HI)
            return STATE_HI;
        if (v < STATE_LO)
            return STATE_LO;
        return v;
    endfunction

    // quadratic drag -k|v|v
    function automatic longint drag_accel(input longint v);
        logic [63:0] sq;
        longint      d;
        sq = scaled_product(magnitude(v), magnitude(v), FRAC_BITS);
        d  = scaled_product(model_cfg.drag_k, sq, K_FRAC);
        return (v < 0) ? d : -d;
    endfunction

    // apply one command to the flight state and report the state after it
    function automatic result_t integrate_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [LVX_W-1:0] vx,
                                                  input logic [LVY_W-1:0] vy,
                                                  input logic [LH_W-1:0]  height);
        logic [63:0] dt, dt2;
        longint      ay, ax, tx, ty, mg, grav;
        result_t     r;
        if (cmd == CMD_LAUNCH)
        begin
            fl_x      = 0;
            fl_y      = height;
            fl_vx     = vx;
            fl_vy     = vy;
            fl_clock  = 0;
            fl_peak   = 0;
            fl_hit_at = 0;
            fl_hit    = 1'b0;
            fl_down   = 1'b0;
        end
        else if (!fl_down)
        begin
            dt   = model_cfg.time_step;
            dt2  = dt * dt;
            grav = model_cfg.gravity;
            tx   = model_cfg.target_x;
            ty   = model_cfg.target_y;
            mg   = model_cfg.target_margin;
            ay   = clamp40(drag_accel(fl_vy) - grav);
            ax   = clamp40(drag_accel(fl_vx));
            // vertical first, then horizontal
            fl_y = clamp40(fl_y + scaled_signed(fl_vy, dt, FRAC_BITS)
                           + scaled_signed(ay, dt2, 2 * FRAC_BITS + 1));
            if (fl_y > fl_peak)
                fl_peak = fl_y;
            fl_vy = clamp40(fl_vy + scaled_signed(ay, dt, FRAC_BITS));
            fl_x  = clamp40(fl_x + scaled_signed(fl_vx, dt, FRAC_BITS)
                            + scaled_signed(ax, dt2, 2 * FRAC_BITS + 1));
            fl_vx = clamp40(fl_vx + scaled_signed(ax, dt, FRAC_BITS));
            // strictly inside the target window stamps the time before the step
            if (fl_x < tx + mg && fl_x > tx - mg && fl_y < ty + mg && fl_y > ty - mg)
            begin
                fl_hit_at = fl_clock;
                fl_hit    = 1'b1;
            end
            fl_clock = fl_clock + dt;
            if (fl_clock > TIME_CAP)
                fl_clock = TIME_CAP;
            if (fl_y < 0)
                fl_down = 1'b1;
        end
        r.pos_x       = STATE_W'(fl_x);
        r.pos_y       = STATE_W'(fl_y);
        r.vel_x       = STATE_W'(fl_vx);
        r.vel_y       = STATE_W'(fl_vy);
        r.elapsed     = TIME_W'(fl_clock);
        r.peak_height = PEAK_W'(fl_peak);
        r.hit_time    = '0;
        if (fl_hit)
            r.hit_time = TIME_W'(fl_hit_at);
        r.hit_valid   = fl_hit;
        r.landed      = fl_down;
        return r;
    endfunction

    // command transaction with a random lead-in gap, none when eager
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [LVX_W-1:0] vx,
                                input logic [LVY_W-1:0] vy, input logic [LH_W-1:0] height,
                                input bit fixed, input result_t fixed_state);
        int      gap;
        result_t predicted;
        gap = tx_eager ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.launch_vx     <= vx;
        req_ch.launch_vy     <= vy;
        req_ch.launch_height <= height;
        do @(posedge clk); while (!req_ch.ready);
        if (cmd == CMD_LAUNCH || !fl_down)
            live_items++;
        predicted = integrate_command(cmd, vx, vy, height);
        expected_states = {expected_states, (fixed ? fixed_state : predicted)};
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {REG_LSB{1'b0}}};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DRAG_K:        model_cfg.drag_k        = value[DRAG_K_W-1:0];
            REG_GRAVITY:       model_cfg.gravity       = value[GRAV_W-1:0];
            REG_TIME_STEP:     model_cfg.time_step     = value[DT_W-1:0];
            REG_TARGET_X:      model_cfg.target_x      = value[TGT_W-1:0];
            REG_TARGET_Y:      model_cfg.target_y      = value[TGT_W-1:0];
            REG_TARGET_MARGIN: model_cfg.target_margin = value[MARGIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop offering commands and let every result come back
    task automatic drain_block();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_states.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // zero, stated low, stated high, all ones, reset value, else random typical
    function automatic logic [63:0] setting(input int choice, input logic [63:0] low,
                                            input logic [63:0] high, input logic [63:0] deflt,
                                            input int unsigned rnd_lo, input int unsigned rnd_hi);
        case (choice)
            0:       return '0;
            1:       return low;
            2:       return high;
            3:       return '1;
            4:       return deflt;
            default: return 64'($urandom_range(rnd_lo, rnd_hi));
        endcase
    endfunction

    task automatic program_phase(input int phase);
        int pick [6];
        foreach (pick[i])
            pick[i] = (phase < 6) ? (phase + i) % 6 : $urandom_range(0, 11);
        write_register(REG_DRAG_K,
                       setting(pick[0], 0, 64'hFFFF_FFFF, DRAG_K_RST, 0, 524288));
        write_register(REG_GRAVITY,
                       setting(pick[1], 0, 6553600, GRAVITY_RST, 0, 1310720));
        write_register(REG_TIME_STEP,
                       setting(pick[2], 66, 655360, TIME_STEP_RST, 66, 131072));
        write_register(REG_TARGET_X,
                       setting(pick[3], 0, 64'd6553600000, TARGET_X_RST, 0, 3276800));
        write_register(REG_TARGET_Y,
                       setting(pick[4], 0, 64'd6553600000, TARGET_Y_RST, 0, 1966080));
        write_register(REG_TARGET_MARGIN,
                       setting(pick[5], 0, 6553600, TARGET_MARGIN_RST, 0, 1310720));
    endtask

    function automatic logic [LVX_W-1:0] launch_speed();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return LVX_W'(19660800);
            3:       return LVX_W'($urandom);
            default: return LVX_W'($urandom_range(0, 3276800));
        endcase
    endfunction

    function automatic logic [LH_W-1:0] launch_height();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return LH_W'(65536000);
            3:       return LH_W'($urandom);
            default: return LH_W'($urandom_range(0, 655360));
        endcase
    endfunction

    // one flight: optional junk, launch, advances until landing or a cut-off, a few after
    task automatic run_flight(input bit hold_output);
        int noise, limit, extra, n;
        noise = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        repeat (noise)
            send_command(CMD_W'($urandom), LVX_W'($urandom), LVY_W'($urandom),
                         LH_W'($urandom), 1'b0, '0);
        if (hold_output)
            rx_hold_req = 1'b1;
        send_command(CMD_LAUNCH, launch_speed(), launch_speed(), launch_height(), 1'b0, '0);
        limit = $urandom_range(3, 60);
        extra = hold_output ? 8 : $urandom_range(0, 2);
        n = 0;
        while (n < limit && !fl_down)
        begin
            send_command(CMD_ADVANCE, LVX_W'($urandom), LVY_W'($urandom), LH_W'($urandom),
                         1'b0, '0);
            n++;
        end
        repeat (extra)
            send_command(CMD_ADVANCE, LVX_W'($urandom), LVY_W'($urandom), LH_W'($urandom),
                         1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            failures++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic check_state(input result_t got);
        result_t want;
        if (expected_states.size() == 0)
        begin
            failures++;
            $error("result transaction with nothing outstanding");
            return;
        end
        want = expected_states.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("vel_x", want.vel_x, got.vel_x);
        check_field("vel_y", want.vel_y, got.vel_y);
        check_field("elapsed", want.elapsed, got.elapsed);
        check_field("peak_height", want.peak_height, got.peak_height);
        check_field("hit_time", want.hit_time, got.hit_time);
        check_field("hit_valid", want.hit_valid, got.hit_valid);
        check_field("landed", want.landed, got.landed);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int      pause;
        result_t got;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                pause = rx_eager ? 0 : $urandom_range(0, 5);
                if (pause > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (pause) @(negedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            got = '{rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.vel_x, rsp_ch.vel_y, rsp_ch.elapsed,
                    rsp_ch.peak_height, rsp_ch.hit_time, rsp_ch.hit_valid, rsp_ch.landed};
            check_state(got);
        end
    end

    // run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("projectile_drag_integrator_top: mismatch");
        $finish;
    end

    // command side and overall sequence
    initial
    begin : command_source
        int phase, flights, f;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_LAUNCH;
        req_ch.launch_vx     = '0;
        req_ch.launch_vy     = '0;
        req_ch.launch_height = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        model_cfg = '{DRAG_K_RST, GRAVITY_RST, TIME_STEP_RST, TARGET_X_RST, TARGET_Y_RST,
                      TARGET_MARGIN_RST};
        fl_x = 0; fl_y = 0; fl_vx = 0; fl_vy = 0; fl_peak = 0;
        fl_clock = 0; fl_hit_at = 0; fl_hit = 1'b0; fl_down = 1'b1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (opening_rows[i])
            send_command(opening_rows[i].cmd, opening_rows[i].vx, opening_rows[i].vy,
                         opening_rows[i].height, opening_rows[i].fixed,
                         opening_rows[i].fixed_state);

        // random phases, each with its own register setting
        live_items = 0;
        phase = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            drain_block();
            program_phase(phase);
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            flights  = $urandom_range(1, 3);
            for (f = 0; f < flights; f++)
                run_flight(phase == HOLD_PHASE && f == 0);
            phase++;
        end

        drain_block();
        repeat (END_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("projectile_drag_integrator_top: match");
        else
            $display("projectile_drag_integrator_top: mismatch");
        $finish;
    end

endmodule
